/* rtl/core/akfe_pkg.sv */
// ----------------------------------------------------------------------------
// akfe_pkg: shared types and constants of the kernel density field evaluator
// holds the default sizes, opcodes, register indexes and kernel word layout
// ----------------------------------------------------------------------------
package akfe_pkg;

   localparam int MAX_KERNELS_DEF = 1024;
   localparam int GRID_DIM_DEF    = 256;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int KWORDS   = 13;
   localparam int KW_BITS  = 4;
   localparam int FIELD_W  = 40;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [2:0] CSR_SPACING  = 3'd3;
   localparam logic [2:0] CSR_KCOUNT   = 3'd4;

   localparam logic [KW_BITS-1:0] KW_WEIGHT = 4'd3;

endpackage

/* rtl/core/akfe_mul.sv */
// ----------------------------------------------------------------------------
// akfe_mul: shared signed multiplier with a registered product
// one 33x33 signed multiply per cycle, product available the next cycle
// ----------------------------------------------------------------------------
module akfe_mul (
   input  logic                clock,
   input  logic signed [32:0]  a,
   input  logic signed [32:0]  b,
   output logic signed [65:0]  p
);
   logic signed [65:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end

   assign p = p_ff;
endmodule

/* rtl/core/anisotropic_kernel_field_eval_unit.sv */
// ----------------------------------------------------------------------------
// anisotropic_kernel_field_eval_unit: anisotropic kernel density field
// a load item with slot and word in range is written as it is accepted; an
// evaluation visits n = min(kernel_count, MAX_KERNELS) kernels, then raises
// rsp_tvalid; a kernel whose support misses the point skips the weight steps;
// the work is bound by one shared multiplier and one store read port
// one item is in work at a time; the result waits in an output register and
// the next transfer is taken the cycle after the result transfer
// synchronous active-high reset clears the control state and resets the configuration registers
// the kernel store is not cleared and is undefined until written
// ----------------------------------------------------------------------------
module anisotropic_kernel_field_eval_unit #(
   parameter int MAX_KERNELS = akfe_pkg::MAX_KERNELS_DEF,
   parameter int GRID_DIM    = akfe_pkg::GRID_DIM_DEF,
   parameter int FRAC_BITS   = akfe_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,    // op
   // slot[9:0], word_index[13:10], word_value[45:14], grid_x[53:46],
   // grid_y[61:54], grid_z[69:62], zero fill [71:70]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // field_value[39:0]
   output logic        rsp_tuser,    // saturated
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import akfe_pkg::*;

   localparam int KB   = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
   localparam int DEPTH = MAX_KERNELS * KWORDS;
   localparam int AB   = $clog2(DEPTH);
   localparam int CB   = KB + 1;
   localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_PT, S_RD, S_R, S_DOT, S_Q2, S_QA, S_QB, S_QC, S_W, S_NEXT, S_DONE
   } state_type;

   // configuration
   logic signed [31:0] org_ff [3];
   logic [30:0]        spc_ff;
   logic [10:0]        kcnt_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0; org_ff[1] <= '0; org_ff[2] <= '0;
         spc_ff    <= 31'd65536;
         kcnt_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X: org_ff[0] <= csr_data;
            CSR_ORIGIN_Y: org_ff[1] <= csr_data;
            CSR_ORIGIN_Z: org_ff[2] <= csr_data;
            CSR_SPACING:  spc_ff    <= csr_data[30:0];
            CSR_KCOUNT:   kcnt_ff   <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic [9:0]         f_slot;
   logic [3:0]         f_word;
   logic [31:0]        f_val;
   logic [7:0]         f_grid [3];
   assign f_slot    = req_tdata[9:0];
   assign f_word    = req_tdata[13:10];
   assign f_val     = req_tdata[45:14];
   assign f_grid[0] = req_tdata[53:46];
   assign f_grid[1] = req_tdata[61:54];
   assign f_grid[2] = req_tdata[69:62];

   // kernel store, one write port and one read port, both usable in a cycle
   logic [31:0]   mem [DEPTH];
   logic [AB-1:0] rd_addr;
   logic [31:0]   rd_q_ff;
   logic          wr_en;
   logic [AB-1:0] wr_addr;

   assign wr_en   = req_tvalid && req_tready && (req_tuser == OP_LOAD)
                    && ({22'd0, f_slot} < MAX_KERNELS) && (f_word < KWORDS);
   assign wr_addr = AB'(32'(f_slot) * KWORDS + 32'(f_word));

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= f_val;
      rd_q_ff <= mem[rd_addr];
   end

   // shared multiplier
   logic signed [32:0] ma, mb;
   logic signed [65:0] mp;
   akfe_mul u_mul (.clock(clock), .a(ma), .b(mb), .p(mp));

   // sequencer state
   state_type          st_ff;
   logic [5:0]         ph_ff;      // step inside a state
   logic [KB-1:0]      k_ff;
   logic [CB-1:0]      n_ff;
   logic [AB-1:0]      base_ff;    // kernel base address
   logic [7:0]         g_ff [3];
   logic signed [40:0] pt_ff [3];  // point, wide enough for the sum
   logic signed [31:0] r_ff [3];
   logic signed [49:0] d_ff;       // one dot product
   logic [1:0]         ax_ff;
   logic               out_ff;     // any axis outside
   logic signed [33:0] q2_ff;
   logic signed [32:0] q_ff;
   logic signed [32:0] q3_ff;
   logic signed [31:0] w_ff;
   logic signed [66:0] sum_ff;
   logic               sat_ff;
   logic               rv_ff;
   logic [39:0]        rval_ff;
   logic               rsat_ff;

   assign req_tready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rval_ff;
   assign rsp_tuser  = rsat_ff;

   function automatic logic [7:0] gclip(input logic [7:0] g);
      if (32'(g) > GRID_DIM - 1) return 8'(GRID_DIM - 1);
      return g;
   endfunction

   function automatic logic signed [65:0] fshift(input logic signed [65:0] v);
      return v >>> FRAC_BITS;
   endfunction

   // multiplier operand select
   logic [1:0] pi;
   assign pi = ph_ff[1:0];
   always_comb begin
      ma = '0; mb = '0;
      case (st_ff)
         S_PT:  begin
            ma = {25'd0, g_ff[2'(ph_ff < 3 ? ph_ff : 6'd0)]};
            mb = {2'b00, spc_ff};
         end
         S_DOT: begin
            ma = {r_ff[pi][31], r_ff[pi]};
            mb = {rd_q_ff[31], rd_q_ff};
         end
         S_Q2:  begin ma = d_ff[32:0]; mb = d_ff[32:0]; end
         S_QA:  begin ma = q_ff; mb = q_ff; end
         S_QB:  begin ma = q3_ff; mb = q_ff; end
         S_W:   begin ma = {w_ff[31], w_ff}; mb = q3_ff; end
         default: ;
      endcase
   end

   // read address: kernel base plus word
   always_comb begin
      rd_addr = base_ff;
      case (st_ff)
         S_RD:  rd_addr = base_ff + AB'(ph_ff);
         S_R:   rd_addr = base_ff + AB'(4 + 3 * ax_ff);
         S_DOT: rd_addr = base_ff + AB'(4 + 3 * ax_ff) + AB'(ph_ff[1:0] + 2'd1);
         default: rd_addr = base_ff + AB'(KW_WEIGHT);
      endcase
   end

   logic signed [40:0] rdiff;
   logic signed [49:0] dsum;
   logic signed [66:0] fin;
   always_comb begin
      rdiff = pt_ff[2'(ph_ff - 6'd1)] - 41'(signed'(rd_q_ff));
      dsum  = d_ff + 50'(fshift(mp));
      fin   = sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         rv_ff  <= 1'b0;
         ph_ff  <= '0;
      end else begin
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (req_tvalid && req_tready && req_tuser == OP_EVAL) begin
               g_ff[0] <= gclip(f_grid[0]);
               g_ff[1] <= gclip(f_grid[1]);
               g_ff[2] <= gclip(f_grid[2]);
               n_ff    <= (32'(kcnt_ff) > MAX_KERNELS) ? CB'(MAX_KERNELS) : CB'(kcnt_ff);
               sum_ff  <= '0;
               sat_ff  <= 1'b0;
               k_ff    <= '0;
               base_ff <= '0;
               ph_ff   <= '0;
               st_ff   <= S_PT;
            end
            // point = origin + grid * spacing, product registered in the shared multiplier
            S_PT: begin
               if (ph_ff != 0)
                  pt_ff[2'(ph_ff - 6'd1)] <= 41'(signed'(org_ff[2'(ph_ff - 6'd1)]))
                                             + 41'(mp);
               if (ph_ff == 3) begin
                  ph_ff <= '0;
                  st_ff <= (n_ff == 0) ? S_DONE : S_RD;
               end else ph_ff <= ph_ff + 6'd1;
            end
            // read centre words, then r with clipping
            S_RD: begin
               if (ph_ff != 0) begin
                  if (rdiff > 41'sh7FFFFFFF) begin
                     r_ff[2'(ph_ff - 6'd1)] <= 32'h7FFFFFFF; sat_ff <= 1'b1;
                  end else if (rdiff < -41'sh80000000) begin
                     r_ff[2'(ph_ff - 6'd1)] <= 32'h80000000; sat_ff <= 1'b1;
                  end else r_ff[2'(ph_ff - 6'd1)] <= rdiff[31:0];
               end
               if (ph_ff == 3) begin
                  ph_ff  <= '0;
                  ax_ff  <= '0;
                  out_ff <= 1'b0;
                  q2_ff  <= '0;
                  st_ff  <= S_R;
               end else ph_ff <= ph_ff + 6'd1;
            end
            // prime the read of the current axis's first word
            S_R: begin
               d_ff  <= '0;
               ph_ff <= '0;
               st_ff <= S_DOT;
            end
            // ph 0..2 issue products, 1..3 accumulate
            S_DOT: begin
               if (ph_ff != 0) d_ff <= dsum;
               if (ph_ff == 3) begin
                  ph_ff <= '0;
                  st_ff <= S_Q2;
               end else ph_ff <= ph_ff + 6'd1;
            end
            S_Q2: begin
               if (ph_ff == 0) begin
                  if (d_ff >= 50'(ONE) || d_ff <= -50'(ONE)) out_ff <= 1'b1;
                  ph_ff <= 6'd1;
               end else begin
                  q2_ff <= q2_ff + 34'(mp >>> FRAC_BITS);
                  ph_ff <= '0;
                  if (ax_ff == 2) st_ff <= S_QA;
                  else begin
                     ax_ff <= ax_ff + 2'd1;
                     st_ff <= S_R;
                  end
               end
            end
            S_QA: begin
               if (ph_ff == 0) begin
                  if (out_ff || q2_ff >= 34'(ONE)) st_ff <= S_NEXT;
                  else begin
                     q_ff  <= 33'(ONE) - 33'(q2_ff);
                     ph_ff <= 6'd1;
                  end
               end else if (ph_ff == 1) ph_ff <= 6'd2;
               else begin
                  q3_ff <= 33'(mp >>> FRAC_BITS);
                  ph_ff <= '0;
                  st_ff <= S_QB;
               end
            end
            S_QB: begin
               if (ph_ff == 0) ph_ff <= 6'd1;
               else begin
                  q3_ff <= 33'(mp >>> FRAC_BITS);
                  w_ff  <= rd_q_ff;
                  ph_ff <= '0;
                  st_ff <= S_W;
               end
            end
            S_W: begin
               if (ph_ff == 0) ph_ff <= 6'd1;
               else begin
                  sum_ff <= sum_ff + 67'(fshift(mp));
                  ph_ff  <= '0;
                  st_ff  <= S_NEXT;
               end
            end
            S_NEXT: begin
               ph_ff <= '0;
               if (CB'(k_ff) + CB'(1) >= n_ff) st_ff <= S_DONE;
               else begin
                  k_ff    <= k_ff + KB'(1);
                  base_ff <= base_ff + AB'(KWORDS);
                  st_ff   <= S_RD;
               end
            end
            S_DONE: begin
               rv_ff <= 1'b1;
               if (fin < 0) begin
                  rval_ff <= '0; rsat_ff <= 1'b1;
               end else if (fin > 67'sh0FFFFFFFFFF) begin
                  rval_ff <= '1; rsat_ff <= 1'b1;
               end else begin
                  rval_ff <= fin[39:0]; rsat_ff <= sat_ff;
               end
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // assertions
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req_tready) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_tready) |=> (rv_ff && $stable(rval_ff))) else $error("rsp dropped");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DONE) |=> rv_ff) else $error("no result after eval");
endmodule
